### sv/epsc_pkg.sv
package epsc_pkg;

    // port widths
    localparam int SECS_W  = 32;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int WDAY_W  = 3;

    // pipeline registers ahead of the result register
    localparam int NUM_STAGES = 6;

    // seconds / 86400 done as (seconds >> 7) / 675
    localparam int DAY_LOW_W = 7;
    localparam int DAYQ_W    = SECS_W - DAY_LOW_W;
    localparam int DAYS_W    = 16;
    localparam int DAY_M_W   = 26;
    localparam int DAY_K     = 35;
    localparam logic [DAY_M_W-1:0] DAY_M = 26'd50903317;
    localparam logic [9:0] DAY_DIV_ODD = 10'd675;
    localparam int R675_W = 10;
    localparam int REM_W  = R675_W + DAY_LOW_W;

    // era arithmetic, only eras 4 and 5 are reachable
    localparam int DOE_W = 18;
    localparam logic [DOE_W-1:0] ERA_OFFSET   = 18'd135080;
    localparam logic [DOE_W-1:0] DAYS_PER_ERA = 18'd146097;
    localparam logic [DOE_W-1:0] CENT_DAYS_1  = 18'd36524;
    localparam logic [DOE_W-1:0] CENT_DAYS_2  = 18'd73048;
    localparam logic [DOE_W-1:0] CENT_DAYS_3  = 18'd109572;
    localparam logic [DOE_W-1:0] CENT_DAYS_4  = 18'd146096;
    localparam logic [DOE_W-1:0] DAYS_PER_YEAR = 18'd365;
    localparam logic [YEAR_W-1:0] ERA4_YEAR = 12'd1600;
    localparam logic [YEAR_W-1:0] ERA5_YEAR = 12'd2000;

    // x / 365 as (x * Y365_M) >> Y365_K, exact below 2^18
    localparam int Y365_M_W = 18;
    localparam int Y365_K   = 26;
    localparam logic [Y365_M_W-1:0] Y365_M = 18'd183860;
    localparam int Q1460_W = 8;
    localparam int YOE_W   = 9;
    localparam int DOY_W   = 9;
    localparam int MP_W    = 4;

    // time of day
    localparam int HR_M_W = 13;
    localparam int HR_K   = 20;
    localparam logic [HR_M_W-1:0] HR_M = 13'd4661;
    localparam int ROH_W  = 12;
    localparam logic [ROH_W-1:0] SECS_PER_HOUR = 12'd3600;
    localparam int MN_M_W = 11;
    localparam int MN_K   = 14;
    localparam logic [MN_M_W-1:0] MN_M = 11'd1093;
    localparam logic [SEC_W-1:0] SECS_PER_MIN = 6'd60;

    // march-based month index
    localparam logic [MP_W-1:0] MP_JANUARY = 4'd10;
    localparam int MONTHS = 12;

    typedef struct packed {
        logic st1;
        logic st2;
        logic st3;
        logic st4;
    } stage_en_t;

    // first day of year for each march-based month
    function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] s;
        unique case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

### sv/epsc_civil.sv
module epsc_civil (
    input  logic                         clk,
    input  epsc_pkg::stage_en_t          en,
    input  logic [epsc_pkg::DAYS_W-1:0]  days,
    output logic [epsc_pkg::YEAR_W-1:0]  year,
    output logic [epsc_pkg::MONTH_W-1:0] month,
    output logic [epsc_pkg::DAY_W-1:0]   day,
    output logic [epsc_pkg::WDAY_W-1:0]  weekday
);
    import epsc_pkg::*;

    // octal digit folding, 8 is 1 mod 7
    function automatic logic [WDAY_W-1:0] mod7(input logic [DAYS_W:0] v);
        logic [5:0] s1;
        logic [3:0] s2;
        s1 = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9])
           + 6'(v[14:12]) + 6'(v[16:15]);
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        if (s2 >= 4'd7)
        begin
            s2 = s2 - 4'd7;
        end
        return s2[WDAY_W-1:0];
    endfunction

    // stage 1: day of era, era, weekday
    logic [DOE_W-1:0]  doe_raw;
    logic              era1_next;
    logic [DOE_W-1:0]  doe1_next;
    logic [WDAY_W-1:0] wd1_next;
    logic [DOE_W-1:0]  doe1_reg;
    logic              era1_reg;
    logic [WDAY_W-1:0] wd1_reg;

    always_comb
    begin
        doe_raw   = DOE_W'(days) + ERA_OFFSET;
        era1_next = (doe_raw >= DAYS_PER_ERA);
        doe1_next = era1_next ? (doe_raw - DAYS_PER_ERA) : doe_raw;
        wd1_next  = mod7(17'(days) + 17'd4);
    end

    always_ff @(posedge clk)
    begin
        if (en.st1)
        begin
            doe1_reg <= doe1_next;
            era1_reg <= era1_next;
            wd1_reg  <= wd1_next;
        end
    end

    // stage 2: leap corrected day count
    logic [DOE_W-Y365_K+Y365_M_W+Y365_K-3:0] q1460_prod;
    logic [Q1460_W-1:0] q1460;
    logic [2:0]         q_cent;
    logic               q_era;
    logic [DOE_W-1:0]   a2_next;
    logic [DOE_W-1:0]   a2_reg;
    logic [DOE_W-1:0]   doe2_reg;
    logic               era2_reg;
    logic [WDAY_W-1:0]  wd2_reg;

    always_comb
    begin
        q1460_prod = doe1_reg[DOE_W-1:2] * Y365_M;
        q1460  = q1460_prod[Y365_K +: Q1460_W];
        q_cent = 3'(doe1_reg >= CENT_DAYS_1) + 3'(doe1_reg >= CENT_DAYS_2)
               + 3'(doe1_reg >= CENT_DAYS_3) + 3'(doe1_reg >= CENT_DAYS_4);
        q_era  = (doe1_reg == CENT_DAYS_4);
        a2_next = doe1_reg - DOE_W'(q1460) + DOE_W'(q_cent) - DOE_W'(q_era);
    end

    always_ff @(posedge clk)
    begin
        if (en.st2)
        begin
            a2_reg   <= a2_next;
            doe2_reg <= doe1_reg;
            era2_reg <= era1_reg;
            wd2_reg  <= wd1_reg;
        end
    end

    // stage 3: year of era
    logic [DOE_W+Y365_M_W-1:0] yoe_prod;
    logic [YOE_W-1:0]  yoe3_reg;
    logic [DOE_W-1:0]  doe3_reg;
    logic              era3_reg;
    logic [WDAY_W-1:0] wd3_reg;

    assign yoe_prod = a2_reg * Y365_M;

    always_ff @(posedge clk)
    begin
        if (en.st3)
        begin
            yoe3_reg <= yoe_prod[Y365_K +: YOE_W];
            doe3_reg <= doe2_reg;
            era3_reg <= era2_reg;
            wd3_reg  <= wd2_reg;
        end
    end

    // stage 4: day of year, march-based year
    logic [1:0]        q_hund;
    logic [DOE_W-1:0]  year_start;
    logic [DOE_W-1:0]  doy_full;
    logic [YEAR_W-1:0] yr4_next;
    logic [DOY_W-1:0]  doy4_reg;
    logic [YEAR_W-1:0] yr4_reg;
    logic [WDAY_W-1:0] wd4_reg;

    always_comb
    begin
        q_hund = 2'(yoe3_reg >= 9'd100) + 2'(yoe3_reg >= 9'd200)
               + 2'(yoe3_reg >= 9'd300);
        year_start = DOE_W'(yoe3_reg) * DAYS_PER_YEAR + DOE_W'(yoe3_reg >> 2)
                   - DOE_W'(q_hund);
        doy_full = doe3_reg - year_start;
        yr4_next = (era3_reg ? ERA5_YEAR : ERA4_YEAR) + YEAR_W'(yoe3_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.st4)
        begin
            doy4_reg <= doy_full[DOY_W-1:0];
            yr4_reg  <= yr4_next;
            wd4_reg  <= wd3_reg;
        end
    end

    // final step: month from the month start table
    logic [MP_W-1:0]  mp;
    logic [DOY_W-1:0] dom_full;

    always_comb
    begin
        mp = '0;
        for (int i = 1; i < MONTHS; i++)
        begin
            if (doy4_reg >= month_start(MP_W'(i)))
            begin
                mp = mp + 4'd1;
            end
        end
        dom_full = doy4_reg - month_start(mp) + 9'd1;
        day      = dom_full[DAY_W-1:0];
        if (mp >= MP_JANUARY)
        begin
            month = mp - 4'd9;
            year  = yr4_reg + 12'd1;
        end
        else
        begin
            month = mp + 4'd3;
            year  = yr4_reg;
        end
        weekday = wd4_reg;
    end

endmodule

### sv/epsc_tod.sv
module epsc_tod (
    input  logic                            clk,
    input  epsc_pkg::stage_en_t             en,
    input  logic [epsc_pkg::DAYQ_W-1:0]     dq,
    input  logic [epsc_pkg::DAY_LOW_W-1:0]  low,
    input  logic [epsc_pkg::DAYS_W-1:0]     days,
    output logic [epsc_pkg::HOUR_W-1:0]     hour,
    output logic [epsc_pkg::MIN_W-1:0]      minute,
    output logic [epsc_pkg::SEC_W-1:0]      second
);
    import epsc_pkg::*;

    // stage 1: seconds into the day
    logic [DAYQ_W-1:0] r675_full;
    logic [REM_W-1:0]  rem1_reg;

    assign r675_full = dq - DAYQ_W'(days) * DAYQ_W'(DAY_DIV_ODD);

    always_ff @(posedge clk)
    begin
        if (en.st1)
        begin
            rem1_reg <= {r675_full[R675_W-1:0], low};
        end
    end

    // stage 2: hour, (rem >> 4) / 225
    logic [REM_W-4+HR_M_W-1:0] hr_prod;
    logic [HOUR_W-1:0] hr2_reg;
    logic [REM_W-1:0]  rem2_reg;

    assign hr_prod = rem1_reg[REM_W-1:4] * HR_M;

    always_ff @(posedge clk)
    begin
        if (en.st2)
        begin
            hr2_reg  <= hr_prod[HR_K +: HOUR_W];
            rem2_reg <= rem1_reg;
        end
    end

    // stage 3: seconds into the hour
    logic [REM_W-1:0]  roh_full;
    logic [HOUR_W-1:0] hr3_reg;
    logic [ROH_W-1:0]  roh3_reg;

    assign roh_full = rem2_reg - REM_W'(hr2_reg) * REM_W'(SECS_PER_HOUR);

    always_ff @(posedge clk)
    begin
        if (en.st3)
        begin
            hr3_reg  <= hr2_reg;
            roh3_reg <= roh_full[ROH_W-1:0];
        end
    end

    // stage 4: minute, (roh >> 2) / 15
    logic [ROH_W-2+MN_M_W-1:0] mn_prod;
    logic [HOUR_W-1:0] hr4_reg;
    logic [MIN_W-1:0]  mn4_reg;
    logic [ROH_W-1:0]  roh4_reg;

    assign mn_prod = roh3_reg[ROH_W-1:2] * MN_M;

    always_ff @(posedge clk)
    begin
        if (en.st4)
        begin
            hr4_reg  <= hr3_reg;
            mn4_reg  <= mn_prod[MN_K +: MIN_W];
            roh4_reg <= roh3_reg;
        end
    end

    // final step: second
    logic [ROH_W-1:0] sc_full;

    assign sc_full = roh4_reg - ROH_W'(mn4_reg) * ROH_W'(SECS_PER_MIN);
    assign hour    = hr4_reg;
    assign minute  = mn4_reg;
    assign second  = sc_full[SEC_W-1:0];

endmodule

### sv/epoch_seconds_to_calendar_unit.sv
// channel   | handshake               | payload
// ----------+-------------------------+------------------------------------------
// request   | secs_valid / secs_ready | epoch_seconds
// result    | cal_valid / cal_ready   | year month day hour minute second weekday
//
// one request per cycle sustained while cal_ready stays high; a result passes through
// the input register, day split, four date/time stages and the result register
// every stage has its own valid bit and moves when the stage after it is free,
// so bubbles close up and requests keep coming while a result waits
// rst_n clears only the valid bits; the datapath registers are not reset
module epoch_seconds_to_calendar_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          secs_valid,
    output logic                          secs_ready,
    input  logic [epsc_pkg::SECS_W-1:0]   epoch_seconds,
    output logic                          cal_valid,
    input  logic                          cal_ready,
    output logic [epsc_pkg::YEAR_W-1:0]   year,
    output logic [epsc_pkg::MONTH_W-1:0]  month,
    output logic [epsc_pkg::DAY_W-1:0]    day,
    output logic [epsc_pkg::HOUR_W-1:0]   hour,
    output logic [epsc_pkg::MIN_W-1:0]    minute,
    output logic [epsc_pkg::SEC_W-1:0]    second,
    output logic [epsc_pkg::WDAY_W-1:0]   weekday
);
    import epsc_pkg::*;

    // stage valids: 0 input reg, 1 day split, 2..5 date and time stages
    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    // stage load enables, top bit is the result register
    logic [NUM_STAGES:0]   en;
    logic                  res_valid_reg;
    stage_en_t             sub_en;

    always_comb
    begin
        en[NUM_STAGES] = !res_valid_reg || cal_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
    end

    assign secs_ready = en[0];
    assign sub_en     = '{st1: en[2], st2: en[3], st3: en[4], st4: en[5]};

    always_comb
    begin
        vld_next[0] = en[0] ? secs_valid : vld_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (en[NUM_STAGES])
            begin
                res_valid_reg <= vld_reg[NUM_STAGES-1];
            end
        end
    end

    // input register
    logic [SECS_W-1:0] secs_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            secs_reg <= epoch_seconds;
        end
    end

    // day split: days = (secs >> 7) / 675 by reciprocal multiply, exact over 32 bits
    logic [DAYQ_W+DAY_M_W-1:0] day_prod;
    logic [DAYS_W-1:0]    days_reg;
    logic [DAYQ_W-1:0]    dq_reg;
    logic [DAY_LOW_W-1:0] low_reg;

    assign day_prod = secs_reg[SECS_W-1:DAY_LOW_W] * DAY_M;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            days_reg <= day_prod[DAY_K +: DAYS_W];
            dq_reg   <= secs_reg[SECS_W-1:DAY_LOW_W];
            low_reg  <= secs_reg[DAY_LOW_W-1:0];
        end
    end

    // date and time of day run side by side with equal depth
    logic [YEAR_W-1:0]  year_c;
    logic [MONTH_W-1:0] month_c;
    logic [DAY_W-1:0]   day_c;
    logic [WDAY_W-1:0]  weekday_c;
    logic [HOUR_W-1:0]  hour_c;
    logic [MIN_W-1:0]   minute_c;
    logic [SEC_W-1:0]   second_c;

    epsc_civil u_civil (
        .clk     (clk),
        .en      (sub_en),
        .days    (days_reg),
        .year    (year_c),
        .month   (month_c),
        .day     (day_c),
        .weekday (weekday_c)
    );

    epsc_tod u_tod (
        .clk    (clk),
        .en     (sub_en),
        .dq     (dq_reg),
        .low    (low_reg),
        .days   (days_reg),
        .hour   (hour_c),
        .minute (minute_c),
        .second (second_c)
    );

    // result register
    logic [YEAR_W-1:0]  year_reg;
    logic [MONTH_W-1:0] month_reg;
    logic [DAY_W-1:0]   day_reg;
    logic [HOUR_W-1:0]  hour_reg;
    logic [MIN_W-1:0]   minute_reg;
    logic [SEC_W-1:0]   second_reg;
    logic [WDAY_W-1:0]  weekday_reg;

    always_ff @(posedge clk)
    begin
        if (en[NUM_STAGES])
        begin
            year_reg    <= year_c;
            month_reg   <= month_c;
            day_reg     <= day_c;
            hour_reg    <= hour_c;
            minute_reg  <= minute_c;
            second_reg  <= second_c;
            weekday_reg <= weekday_c;
        end
    end

    assign cal_valid = res_valid_reg;
    assign year      = year_reg;
    assign month     = month_reg;
    assign day       = day_reg;
    assign hour      = hour_reg;
    assign minute    = minute_reg;
    assign second    = second_reg;
    assign weekday   = weekday_reg;

`ifndef SYNTHESIS
    // every field of a delivered result lies in its calendar range
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        cal_valid |-> (year >= 12'd1970) && (year <= 12'd2106)
                   && (month >= 4'd1) && (month <= 4'd12)
                   && (day >= 5'd1) && (day <= 5'd31)
                   && (hour <= 5'd23) && (minute <= 6'd59)
                   && (second <= 6'd59) && (weekday <= 3'd6))
        else $error("calendar result out of range");

    // an empty input stage always takes a request
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !vld_reg[0] |-> secs_ready)
        else $error("request refused with empty input stage");

    // a finished item moves into a free result register
    a_last_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NUM_STAGES-1] && en[NUM_STAGES]) |=> cal_valid)
        else $error("finished item not delivered");

    // a blocked last stage keeps its item
    a_last_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NUM_STAGES-1] && !en[NUM_STAGES]) |=> vld_reg[NUM_STAGES-1])
        else $error("item lost in last stage");
`endif

endmodule

### bench/calendar_checker.sv
module calendar_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         secs_valid,
    input  logic                         secs_ready,
    input  logic [epsc_pkg::SECS_W-1:0]  epoch_seconds,
    input  logic                         cal_valid,
    input  logic                         cal_ready,
    input  logic [epsc_pkg::YEAR_W-1:0]  year,
    input  logic [epsc_pkg::MONTH_W-1:0] month,
    input  logic [epsc_pkg::DAY_W-1:0]   day,
    input  logic [epsc_pkg::HOUR_W-1:0]  hour,
    input  logic [epsc_pkg::MIN_W-1:0]   minute,
    input  logic [epsc_pkg::SEC_W-1:0]   second,
    input  logic [epsc_pkg::WDAY_W-1:0]  weekday,
    output int                           mismatches,
    output int                           outstanding,
    output int                           results_seen
);
    import epsc_pkg::*;

    typedef struct {
        logic [SECS_W-1:0]  secs;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic [WDAY_W-1:0]  weekday;
    } calendar_t;

    calendar_t expected_dates[$];

    initial
    begin
        mismatches   = 0;
        outstanding  = 0;
        results_seen = 0;
    end

    // civil date from day count, march-based years in 400-year eras
    function automatic calendar_t civil_from_epoch(input logic [SECS_W-1:0] secs);
        int unsigned days, rest, z, era, doe, yoe, yr, doy, mp, dom, mon;
        calendar_t c;
        days = secs / 32'd86400;
        rest = secs % 32'd86400;
        z    = days + 32'd719468;
        era  = z / 32'd146097;
        doe  = z - era * 32'd146097;
        yoe  = (doe - doe / 32'd1460 + doe / 32'd36524 - doe / 32'd146096) / 32'd365;
        yr   = yoe + era * 32'd400;
        doy  = doe - (32'd365 * yoe + yoe / 32'd4 - yoe / 32'd100);
        mp   = (32'd5 * doy + 32'd2) / 32'd153;
        dom  = doy - (32'd153 * mp + 32'd2) / 32'd5 + 32'd1;
        mon  = (mp < 32'd10) ? mp + 32'd3 : mp - 32'd9;
        if (mon <= 32'd2)
        begin
            yr = yr + 32'd1;
        end
        c.secs    = secs;
        c.year    = YEAR_W'(yr);
        c.month   = MONTH_W'(mon);
        c.day     = DAY_W'(dom);
        c.hour    = HOUR_W'(rest / 32'd3600);
        c.minute  = MIN_W'((rest % 32'd3600) / 32'd60);
        c.second  = SEC_W'(rest % 32'd60);
        c.weekday = WDAY_W'((days + 32'd4) % 32'd7);
        return c;
    endfunction

    task automatic compare_field(input string name, input logic [SECS_W-1:0] secs,
                                 input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch for epoch %0d, expected %0d, actual %0d",
                     $time, name, secs, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        calendar_t want;
        if (rst_n)
        begin
            if (secs_valid && secs_ready)
            begin
                expected_dates.push_back(civil_from_epoch(epoch_seconds));
            end
            if (cal_valid && cal_ready)
            begin
                results_seen++;
                if (expected_dates.size() == 0)
                begin
                    $display("%0t: result with no request waiting, %s %0d-%0d-%0d",
                             $time, "expected none, actual", year, month, day);
                    mismatches++;
                end
                else
                begin
                    want = expected_dates.pop_front();
                    compare_field("year", want.secs, 32'(want.year), 32'(year));
                    compare_field("month", want.secs, 32'(want.month), 32'(month));
                    compare_field("day", want.secs, 32'(want.day), 32'(day));
                    compare_field("hour", want.secs, 32'(want.hour), 32'(hour));
                    compare_field("minute", want.secs, 32'(want.minute), 32'(minute));
                    compare_field("second", want.secs, 32'(want.second), 32'(second));
                    compare_field("weekday", want.secs, 32'(want.weekday),
                                  32'(weekday));
                end
            end
        end
        outstanding = expected_dates.size();
    end

endmodule

### bench/testbench.sv
module testbench;

    import epsc_pkg::*;

    // cycles without any handshake before the run is declared hung
    localparam int WATCHDOG_LIMIT   = 2000;
    // long result back-pressure so the pipeline fills and stalls its input
    localparam int HOLD_OFF_CYCLES  = 300;
    // settle time after the last result
    localparam int SETTLE_CYCLES    = 30;
    localparam int RANDOM_PER_PHASE = 310;
    localparam int NUM_PHASES       = 4;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               secs_valid;
    logic               secs_ready;
    logic [SECS_W-1:0]  epoch_seconds;
    logic               cal_valid;
    logic               cal_ready;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [WDAY_W-1:0]  weekday;

    int  mismatches;
    int  outstanding;
    int  results_seen;
    int  requests_sent = 0;
    // idle and stall odds in percent, changed per phase
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    // raised by the stimulus, cleared by the receiver once the hold-off is over
    bit  hold_off_req   = 1'b0;

    // known values on every input from time zero
    initial
    begin
        rst_n         = 1'b0;
        secs_valid    = 1'b0;
        epoch_seconds = '0;
        cal_ready     = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    epoch_seconds_to_calendar_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .secs_valid    (secs_valid),
        .secs_ready    (secs_ready),
        .epoch_seconds (epoch_seconds),
        .cal_valid     (cal_valid),
        .cal_ready     (cal_ready),
        .year          (year),
        .month         (month),
        .day           (day),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .weekday       (weekday)
    );

    calendar_checker checker_inst (
        .clk           (clk),
        .rst_n         (rst_n),
        .secs_valid    (secs_valid),
        .secs_ready    (secs_ready),
        .epoch_seconds (epoch_seconds),
        .cal_valid     (cal_valid),
        .cal_ready     (cal_ready),
        .year          (year),
        .month         (month),
        .day           (day),
        .hour          (hour),
        .minute        (minute),
        .second        (second),
        .weekday       (weekday),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .results_seen  (results_seen)
    );

    // result side: random stalls, or one long hold-off when asked
    initial
    begin : result_side
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                cal_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                cal_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // hang detection: any accepted request or result restarts the count
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((secs_valid && secs_ready) || (cal_valid && cal_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[epoch_seconds_to_calendar_unit] ERROR");
        $finish;
    end

    // one request; may idle first, then holds valid and data until taken
    // called at a clock edge, returns at the edge where the request is taken
    task automatic offer_request(input logic [SECS_W-1:0] secs);
        if ($urandom_range(99) < send_idle_pct)
        begin
            secs_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        secs_valid    <= 1'b1;
        epoch_seconds <= secs;
        @(posedge clk);
        while (!secs_ready) @(posedge clk);
        requests_sent++;
    endtask

    // stop offering and wait until every predicted result has come back
    task automatic drain_results();
        secs_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // mostly uniform words, plus values hugging midnight and the low range
    function automatic logic [SECS_W-1:0] pick_epoch();
        longint unsigned v;
        int unsigned     pick;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            v = 64'($urandom());
        end
        else if (pick < 85)
        begin
            // around a day boundary, any day in range
            v = longint'($urandom_range(49710)) * 86400;
            case ($urandom_range(3))
                0: v = v;
                1: v = v + 1;
                2: v = v + 86399;
                default: v = v + 86398;
            endcase
            if (v > 64'hFFFF_FFFF)
                v = 64'hFFFF_FFFF;
        end
        else
        begin
            v = 64'($urandom_range(200000000));
        end
        return v[SECS_W-1:0];
    endfunction

    // directed corners: time-of-day rollovers, leap days incl. 2000,
    // the non-leap century 2100, the 2^31 boundary and the top of the range
    logic [SECS_W-1:0] corner_epochs[] = '{
        32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
        32'd68169600,   // 1972-02-29
        32'd946684799, 32'd946684800,   // 1999 -> 2000
        32'd951782400, 32'd951868800,   // 2000-02-29, 2000-03-01
        32'd2147483647, 32'd2147483648,
        32'd4102444799, 32'd4102444800, // 2099 -> 2100
        32'd4107542399, 32'd4107542400, // 2100-02-28 end, 2100-03-01
        32'hAAAA_AAAA, 32'h5555_5555,
        32'hFFFF_FFFE, 32'hFFFF_FFFF
    };

    initial
    begin : stimulus
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at full rate
        foreach (corner_epochs[i])
            offer_request(corner_epochs[i]);
        drain_results();

        // phases: no idling, sender idle, receiver stalling, both
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // mid-way through the full-rate phase, back up the pipeline
                if (phase == 0 && n == 100)
                    hold_off_req = 1'b1;
                offer_request(pick_epoch());
            end
            // sender waits for the pipeline to empty between phases
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d requests: corners, then 4 idle/stall mixes %s %0d cycles",
                 requests_sent, "and a hold-off of", HOLD_OFF_CYCLES);
        $display("%0d results compared field by field, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("[epoch_seconds_to_calendar_unit] OK");
        else
            $display("[epoch_seconds_to_calendar_unit] ERROR");
        $finish;
    end

endmodule

### files.f
sv/epsc_pkg.sv
sv/epsc_civil.sv
sv/epsc_tod.sv
sv/epoch_seconds_to_calendar_unit.sv
bench/calendar_checker.sv
bench/testbench.sv
